[sv/ple_pkg.sv]
package ple_pkg;

  // Default depth of the element store.
  localparam int unsigned CAPACITY_DEF = 64;

  // Fixed field widths of the command and result words.
  localparam int unsigned DataW   = 32;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned PosW    = 7;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LenW    = 7;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT,
    CMD_DELETE,
    CMD_GET,
    CMD_LOCATE,
    CMD_PRED,
    CMD_SUCC,
    CMD_CLEAR
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK,
    ST_RANGE,
    ST_FULL,
    ST_NOTFOUND
  } status_e;

  // Microprogram step addresses.
  typedef enum logic [4:0] {
    S_IDLE,
    S_FIN,
    S_INS_CHK,
    S_INS_FULL,
    S_INS_SHF0,
    S_INS_SHF,
    S_INS_PUT,
    S_DEL_CHK,
    S_DEL_RD,
    S_DEL_CAP,
    S_DEL_SHF,
    S_DEL_DEC,
    S_GET_CHK,
    S_GET_RD,
    S_GET_CAP,
    S_LOC_FIRST,
    S_LOC_LOOP,
    S_PRE_FIRST,
    S_PRE_LOOP,
    S_SUC_FIRST,
    S_SUC_LOOP,
    S_SUC_CAP,
    S_CLR
  } step_e;

  // Branch conditions tested by a step.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_INS_BAD,
    C_FULL,
    C_POS_BAD,
    C_K_AT_POS,
    C_K_END,
    C_K1_END,
    C_HIT,
    C_EQ_NFIRST,
    C_EQ_NLAST,
    C_EQ_OR_END
  } cond_e;

  typedef enum logic [1:0] {RD_NONE, RD_K, RD_KM1, RD_KP1} rd_e;
  typedef enum logic [1:0] {WR_NONE, WR_KP1, WR_KM1, WR_POS} wr_e;
  typedef enum logic [2:0] {K_HOLD, K_COUNT, K_POSM1, K_INC, K_DEC} kop_e;
  typedef enum logic [1:0] {CN_HOLD, CN_INC, CN_DEC, CN_ZERO} cnt_e;
  typedef enum logic [1:0] {VO_HOLD, VO_RD, VO_PREV} vo_e;

  // One control word of the microprogram.
  typedef struct packed {
    logic    idle;
    logic    emit;
    cond_e   cond_t;
    cond_e   cond_x;
    step_e   tgt_t;
    step_e   tgt_f;
    logic    st_en;
    status_e st;
    rd_e     rd;
    wr_e     wr;
    kop_e    kop;
    cnt_e    cnt;
    vo_e     vo;
    logic    fp_en;
  } ctrl_t;

  // The microprogram ROM. Memory access, index, count and value updates happen
  // on every visit of a step; the status code is written only when the branch
  // condition is taken.
  function automatic ctrl_t ucode(input step_e s);
    ctrl_t c;
    c = '0;
    case (s)
      S_IDLE: c.idle = 1'b1;
      S_FIN:  c.emit = 1'b1;
      S_INS_CHK: begin
        c.cond_t = C_INS_BAD; c.st_en = 1'b1; c.st = ST_RANGE;
        c.tgt_t  = S_FIN;     c.tgt_f = S_INS_FULL;
      end
      S_INS_FULL: begin
        c.cond_t = C_FULL; c.st_en = 1'b1; c.st = ST_FULL;
        c.tgt_t  = S_FIN;  c.tgt_f = S_INS_SHF0; c.kop = K_COUNT;
      end
      S_INS_SHF0: begin
        c.cond_t = C_K_AT_POS; c.tgt_t = S_INS_PUT; c.tgt_f = S_INS_SHF;
        c.rd     = RD_KM1;     c.kop   = K_DEC;
      end
      S_INS_SHF: begin
        c.wr     = WR_KP1;
        c.cond_t = C_K_AT_POS; c.tgt_t = S_INS_PUT; c.tgt_f = S_INS_SHF;
        c.rd     = RD_KM1;     c.kop   = K_DEC;
      end
      S_INS_PUT: begin
        c.wr = WR_POS; c.cnt = CN_INC; c.cond_t = C_ALWAYS; c.tgt_t = S_FIN;
      end
      S_DEL_CHK: begin
        c.cond_t = C_POS_BAD; c.st_en = 1'b1; c.st = ST_RANGE;
        c.tgt_t  = S_FIN;     c.tgt_f = S_DEL_RD; c.kop = K_POSM1;
      end
      S_DEL_RD: begin
        c.rd = RD_K; c.kop = K_INC; c.cond_t = C_ALWAYS; c.tgt_t = S_DEL_CAP;
      end
      S_DEL_CAP: begin
        c.vo     = VO_RD;   c.rd    = RD_K;
        c.cond_t = C_K_END; c.tgt_t = S_DEL_DEC; c.tgt_f = S_DEL_SHF;
      end
      S_DEL_SHF: begin
        c.wr     = WR_KM1;   c.rd    = RD_KP1;    c.kop   = K_INC;
        c.cond_t = C_K1_END; c.tgt_t = S_DEL_DEC; c.tgt_f = S_DEL_SHF;
      end
      S_DEL_DEC: begin
        c.cnt = CN_DEC; c.cond_t = C_ALWAYS; c.tgt_t = S_FIN;
      end
      S_GET_CHK: begin
        c.cond_t = C_POS_BAD; c.st_en = 1'b1; c.st = ST_RANGE;
        c.tgt_t  = S_FIN;     c.tgt_f = S_GET_RD; c.kop = K_POSM1;
      end
      S_GET_RD: begin
        c.rd = RD_K; c.cond_t = C_ALWAYS; c.tgt_t = S_GET_CAP;
      end
      S_GET_CAP: begin
        c.vo = VO_RD; c.cond_t = C_ALWAYS; c.tgt_t = S_FIN;
      end
      S_LOC_FIRST: begin
        c.cond_x = C_K_END; c.rd = RD_K; c.kop = K_INC; c.tgt_f = S_LOC_LOOP;
      end
      S_LOC_LOOP: begin
        c.fp_en  = 1'b1;
        c.cond_t = C_HIT;   c.st_en = 1'b1; c.st = ST_OK; c.tgt_t = S_FIN;
        c.cond_x = C_K_END; c.rd = RD_K; c.kop = K_INC; c.tgt_f = S_LOC_LOOP;
      end
      S_PRE_FIRST: begin
        c.cond_x = C_K_END; c.rd = RD_K; c.kop = K_INC; c.tgt_f = S_PRE_LOOP;
      end
      S_PRE_LOOP: begin
        c.vo     = VO_PREV;
        c.cond_t = C_EQ_NFIRST; c.st_en = 1'b1; c.st = ST_OK; c.tgt_t = S_FIN;
        c.cond_x = C_EQ_OR_END; c.rd = RD_K; c.kop = K_INC; c.tgt_f = S_PRE_LOOP;
      end
      S_SUC_FIRST: begin
        c.cond_x = C_K_END; c.rd = RD_K; c.kop = K_INC; c.tgt_f = S_SUC_LOOP;
      end
      S_SUC_LOOP: begin
        c.cond_t = C_EQ_NLAST; c.st_en = 1'b1; c.st = ST_OK; c.tgt_t = S_SUC_CAP;
        c.cond_x = C_EQ_OR_END; c.rd = RD_K; c.kop = K_INC; c.tgt_f = S_SUC_LOOP;
      end
      S_SUC_CAP: begin
        c.vo = VO_RD; c.cond_t = C_ALWAYS; c.tgt_t = S_FIN;
      end
      S_CLR: begin
        c.cnt = CN_ZERO; c.cond_t = C_ALWAYS; c.tgt_t = S_FIN;
      end
      default: c.tgt_f = S_IDLE;
    endcase
    return c;
  endfunction

  // Entry point of the microprogram for each command.
  function automatic step_e entry_step(input cmd_e c);
    step_e s;
    case (c)
      CMD_INSERT: s = S_INS_CHK;
      CMD_DELETE: s = S_DEL_CHK;
      CMD_GET:    s = S_GET_CHK;
      CMD_LOCATE: s = S_LOC_FIRST;
      CMD_PRED:   s = S_PRE_FIRST;
      CMD_SUCC:   s = S_SUC_FIRST;
      CMD_CLEAR:  s = S_CLR;
      default:    s = S_FIN;
    endcase
    return s;
  endfunction

  // Searches start pessimistic and are marked good on a hit.
  function automatic status_e init_status(input cmd_e c);
    status_e st;
    st = ST_OK;
    if (c inside {CMD_LOCATE, CMD_PRED, CMD_SUCC}) begin
      st = ST_NOTFOUND;
    end
    return st;
  endfunction

endpackage

[sv/ple_intf.sv]
interface ple_cmd_if import ple_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CmdW-1:0]         command;
  logic [PosW-1:0]         position;
  logic signed [DataW-1:0] value_in;

  modport source (output valid, command, position, value_in, input ready);
  modport sink (input valid, command, position, value_in, output ready);
endinterface

interface ple_res_if import ple_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [StatusW-1:0]      status;
  logic signed [DataW-1:0] value_out;
  logic [PosW-1:0]         found_position;
  logic [LenW-1:0]         list_length;
  logic                    is_empty;

  modport source (output valid, status, value_out, found_position, list_length, is_empty,
                  input ready);
  modport sink (input valid, status, value_out, found_position, list_length, is_empty,
                output ready);
endinterface

interface ple_cfg_if;
  logic valid;
  logic ready;
  logic locate_mode;

  modport source (output valid, locate_mode, input ready);
  modport sink (input valid, locate_mode, output ready);
endinterface

[sv/positional_list_engine.sv]
// Positional list engine: an ordered list of signed 32-bit values kept in a
// single-port-write, registered-read store of CAPACITY entries. Each command
// word on cmd_i (insert, delete, get, locate, predecessor, successor, clear)
// yields exactly one result word on res_o carrying status, value, found
// position, new length and an empty flag; value and found position read zero
// whenever status is not ok. One command is processed at a time, and the next
// one is taken as soon as the previous result sits in the output register,
// even if the consumer has not yet taken it. The store is walked one entry
// per cycle. The locate rule (equal to, or greater than the key) comes from
// the one-bit cfg_i register, which resets to greater-than and should only
// be written while no command is in flight.
module positional_list_engine import ple_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  ple_cmd_if.sink   cmd_i,
  ple_res_if.source res_o,
  ple_cfg_if.sink   cfg_i
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW  = ((CntW > PosW) ? CntW : PosW) + 1;

  // Sequencer state and the current control word.
  step_e step_q, step_d;
  ctrl_t ctl;

  // Datapath registers.
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  k_q, k_d;
  logic [CntW-1:0]  fpos_q, fpos_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [DataW-1:0] val_q, val_d;
  logic [DataW-1:0] vout_q, vout_d;
  logic [DataW-1:0] prev_q;
  logic [DataW-1:0] rdata_q;
  status_e          status_q, status_d;
  logic             mode_q;

  // Element store.
  logic [DataW-1:0] mem_q [CAPACITY];
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_wa, mem_ra;
  logic [DataW-1:0] mem_wd;

  // Output register.
  logic             res_valid_q, res_valid_d;
  status_e          res_status_q, res_status_d;
  logic [DataW-1:0] res_value_q, res_value_d;
  logic [PosW-1:0]  res_fpos_q, res_fpos_d;
  logic [LenW-1:0]  res_len_q, res_len_d;
  logic             res_empty_q, res_empty_d;

  // Condition evaluation.
  logic [15:0]      cond_vec;
  logic             taken, leave, eq, accept;
  logic [CmpW-1:0]  pos_x, cnt_x, k_x;
  logic [CntW-1:0]  k_m1, k_p1, pos_m1;

  assign ctl    = ucode(step_q);
  assign accept = cmd_i.valid && cmd_i.ready;

  // Commands are taken only when the sequencer rests at its idle step.
  assign cmd_i.ready = ctl.idle;
  assign cfg_i.ready = 1'b1;

  assign res_o.valid          = res_valid_q;
  assign res_o.status         = res_status_q;
  assign res_o.value_out      = res_value_q;
  assign res_o.found_position = res_fpos_q;
  assign res_o.list_length    = res_len_q;
  assign res_o.is_empty       = res_empty_q;

  assign pos_x  = CmpW'(pos_q);
  assign cnt_x  = CmpW'(count_q);
  assign k_x    = CmpW'(k_q);
  assign k_m1   = k_q - CntW'(1);
  assign k_p1   = k_q + CntW'(1);
  assign pos_m1 = CntW'(pos_q - PosW'(1));
  assign eq     = (rdata_q == val_q);

  // All branch conditions are computed in parallel; the control word picks
  // one as the taken condition and one as the early exit.
  always_comb begin
    cond_vec              = '0;
    cond_vec[C_ALWAYS]    = 1'b1;
    cond_vec[C_INS_BAD]   = (pos_x == '0) || (pos_x > cnt_x + CmpW'(1));
    cond_vec[C_FULL]      = (count_q == CntW'(CAPACITY));
    cond_vec[C_POS_BAD]   = (pos_x == '0) || (pos_x > cnt_x);
    cond_vec[C_K_AT_POS]  = (k_x + CmpW'(1) == pos_x);
    cond_vec[C_K_END]     = (k_q == count_q);
    cond_vec[C_K1_END]    = (k_p1 == count_q);
    cond_vec[C_HIT]       = mode_q ? ($signed(rdata_q) > $signed(val_q)) : eq;
    cond_vec[C_EQ_NFIRST] = eq && (k_q != CntW'(1));
    cond_vec[C_EQ_NLAST]  = eq && (k_q != count_q);
    cond_vec[C_EQ_OR_END] = eq || (k_q == count_q);
  end

  assign taken = cond_vec[ctl.cond_t];
  assign leave = cond_vec[ctl.cond_x];

  // Next-state logic: the idle step dispatches a command, the final step
  // loads the output register, and every other step executes its control
  // word and branches.
  always_comb begin
    step_d       = step_q;
    k_d          = k_q;
    count_d      = count_q;
    pos_d        = pos_q;
    val_d        = val_q;
    vout_d       = vout_q;
    fpos_d       = fpos_q;
    status_d     = status_q;
    res_valid_d  = res_valid_q && !res_o.ready;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    res_fpos_d   = res_fpos_q;
    res_len_d    = res_len_q;
    res_empty_d  = res_empty_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_wa       = '0;
    mem_ra       = '0;
    mem_wd       = rdata_q;

    if (ctl.idle) begin
      if (accept) begin
        pos_d    = cmd_i.position;
        val_d    = cmd_i.value_in;
        k_d      = '0;
        vout_d   = '0;
        fpos_d   = '0;
        status_d = init_status(cmd_e'(cmd_i.command));
        step_d   = entry_step(cmd_e'(cmd_i.command));
      end
    end else if (ctl.emit) begin
      // Wait here only while an older result is still unclaimed.
      if (!res_valid_q || res_o.ready) begin
        res_valid_d  = 1'b1;
        res_status_d = status_q;
        res_value_d  = (status_q == ST_OK) ? vout_q : '0;
        res_fpos_d   = (status_q == ST_OK) ? PosW'(fpos_q) : '0;
        res_len_d    = LenW'(count_q);
        res_empty_d  = (count_q == '0);
        step_d       = S_IDLE;
      end
    end else begin
      case (ctl.rd)
        RD_K: begin
          mem_re = 1'b1;
          mem_ra = k_q[AddrW-1:0];
        end
        RD_KM1: begin
          mem_re = 1'b1;
          mem_ra = k_m1[AddrW-1:0];
        end
        RD_KP1: begin
          mem_re = 1'b1;
          mem_ra = k_p1[AddrW-1:0];
        end
        default: ;
      endcase

      // Shifts write the word read on the previous cycle one slot away.
      case (ctl.wr)
        WR_KP1: begin
          mem_we = 1'b1;
          mem_wa = k_p1[AddrW-1:0];
        end
        WR_KM1: begin
          mem_we = 1'b1;
          mem_wa = k_m1[AddrW-1:0];
        end
        WR_POS: begin
          mem_we = 1'b1;
          mem_wa = pos_m1[AddrW-1:0];
          mem_wd = val_q;
        end
        default: ;
      endcase

      case (ctl.kop)
        K_COUNT: k_d = count_q;
        K_POSM1: k_d = pos_m1;
        K_INC:   k_d = k_p1;
        K_DEC:   k_d = k_m1;
        default: ;
      endcase

      case (ctl.cnt)
        CN_INC:  count_d = count_q + CntW'(1);
        CN_DEC:  count_d = count_q - CntW'(1);
        CN_ZERO: count_d = '0;
        default: ;
      endcase

      case (ctl.vo)
        VO_RD:   vout_d = rdata_q;
        VO_PREV: vout_d = prev_q;
        default: ;
      endcase

      // During a locate walk the index already points one past the entry
      // under test, which is exactly its 1-based position.
      if (ctl.fp_en) begin
        fpos_d = k_q;
      end

      if (taken) begin
        if (ctl.st_en) begin
          status_d = ctl.st;
        end
        step_d = ctl.tgt_t;
      end else if (leave) begin
        step_d = S_FIN;
      end else begin
        step_d = ctl.tgt_f;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
      mode_q      <= 1'b1;
    end else begin
      step_q      <= step_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        mode_q <= cfg_i.locate_mode;
      end
    end
  end

  // The previous read word is kept so that a predecessor search can return
  // the entry ahead of its match without a second pass.
  always_ff @(posedge clk_i) begin
    k_q          <= k_d;
    pos_q        <= pos_d;
    val_q        <= val_d;
    vout_q       <= vout_d;
    fpos_q       <= fpos_d;
    status_q     <= status_d;
    prev_q       <= rdata_q;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    res_fpos_q   <= res_fpos_d;
    res_len_q    <= res_len_d;
    res_empty_q  <= res_empty_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_ra];
    end
  end

  // The element count never passes the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("element count exceeds capacity");

  // The count moves by at most one per cycle, or drops to zero on clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == $past(count_q)) || (count_q == $past(count_q) + CntW'(1)) ||
    (count_q == $past(count_q) - CntW'(1)) || (count_q == '0))
    else $error("element count jumped");

  // A failed command never reports a value or a position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && (res_status_q != ST_OK) |->
      (res_value_q == '0) && (res_fpos_q == '0))
    else $error("error result carries data");

endmodule
